@@ rtl/onewire_rom_search_engine_macros.svh @@
// Assertion helpers for the search engine core.
`ifndef ONEWIRE_ROM_SEARCH_ENGINE_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_ENGINE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ORS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ORS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ors_pkg.sv @@
package ors_pkg;

  localparam logic [1:0] FN_FIRST = 2'd0;
  localparam logic [1:0] FN_NEXT  = 2'd1;
  localparam logic [1:0] FN_PAIR  = 2'd2;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_FOUND   = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [7:0] CRC_POLY     = 8'h8c;
  localparam logic [6:0] END_POS      = 7'd65;
  localparam logic [6:0] FAMILY_LIMIT = 7'd9;

  typedef struct packed {
    logic [1:0] func;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } in_item_t;

  typedef struct packed {
    logic        direction;
    logic [1:0]  status;
    logic [63:0] rom_id;
    logic [3:0]  family_discrepancy;
  } out_item_t;

  // One LSB-first step of the reflected Dallas CRC8.
  function automatic logic [7:0] crc_step(logic [7:0] crc, logic b);
    logic [7:0] c;
    c = {1'b0, crc[7:1]};
    if (crc[0] ^ b) c = c ^ CRC_POLY;
    return c;
  endfunction

endpackage

@@ rtl/ors_ifs.sv @@
interface ors_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       presence;
  logic       id_bit;
  logic       complement_bit;

  modport source (output valid, func, presence, id_bit, complement_bit, input ready);
  modport sink   (input valid, func, presence, id_bit, complement_bit, output ready);
endinterface

interface ors_out_if;
  logic        valid;
  logic        ready;
  logic        direction;
  logic [1:0]  status;
  logic [63:0] rom_id;
  logic [3:0]  family_discrepancy;

  modport source (output valid, direction, status, rom_id, family_discrepancy, input ready);
  modport sink   (input valid, direction, status, rom_id, family_discrepancy, output ready);
endinterface

@@ rtl/onewire_rom_search_engine.sv @@
// channel | dir | payload                                          | transfer
// in_ch   | in  | func, presence, id_bit, complement_bit           | valid & ready
// out_ch  | out | direction, status, rom_id, family_discrepancy    | valid & ready
//
// One result word per input word. An accepted word is held in the input register,
// updated combinationally out of it and loaded into the result register once that
// register is empty or drains; one word per cycle is sustained while the output is
// not stalled. Synchronous active-low reset clears all search state and both stage
// valids. A stalled output holds its word and backs up the input register.
module onewire_rom_search_engine
  import ors_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ors_in_if.sink     in_ch,
  ors_out_if.source  out_ch
);

  logic      item_valid;
  in_item_t  item;
  logic      take;
  out_item_t res;

  ors_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ors_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (take),
    .item  (item),
    .res   (res)
  );

  ors_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

@@ rtl/ors_in_stage.sv @@
module ors_in_stage
  import ors_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ors_in_if.sink    in_ch,
  input  logic      take,
  output logic      item_valid,
  output in_item_t  item
);

  logic     valid_r;
  in_item_t item_r;

  // Accept a new word whenever the held one is empty or leaves this cycle.
  assign in_ch.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= '{func: in_ch.func, presence: in_ch.presence,
                  id_bit: in_ch.id_bit, complement_bit: in_ch.complement_bit};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ rtl/ors_core.sv @@
`include "onewire_rom_search_engine_macros.svh"

module ors_core
  import ors_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t res
);

  logic [63:0] rom_r, rom_nxt;
  logic [6:0]  ldisc_r, ldisc_nxt;
  logic [3:0]  fam_r, fam_nxt;
  logic        last_dev_r, last_dev_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [6:0]  lzero_r, lzero_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        active_r, active_nxt;

  logic [5:0]  idx;
  logic        d;
  logic        dir;
  logic [1:0]  status;
  logic        last_dev_eff;

  assign idx = pos_r[5:0] - 6'd1;

  always_comb begin
    rom_nxt      = rom_r;
    ldisc_nxt    = ldisc_r;
    fam_nxt      = fam_r;
    last_dev_nxt = last_dev_r;
    pos_nxt      = pos_r;
    lzero_nxt    = lzero_r;
    crc_nxt      = crc_r;
    active_nxt   = active_r;
    dir          = 1'b0;
    status       = ST_IGNORED;
    last_dev_eff = last_dev_r;

    // Direction from the previous pass, then overridden by what the bus shows.
    if (pos_r < ldisc_r) d = rom_r[idx];
    else                 d = (pos_r == ldisc_r);
    if (item.id_bit != item.complement_bit) d = item.id_bit;
    else if (item.id_bit)                   d = 1'b1;

    case (item.func) inside
      FN_FIRST, FN_NEXT: begin
        // A first search starts from a clean search state.
        if (item.func == FN_FIRST) begin
          ldisc_nxt    = '0;
          fam_nxt      = '0;
          last_dev_nxt = 1'b0;
          last_dev_eff = 1'b0;
        end
        pos_nxt   = 7'd1;
        lzero_nxt = '0;
        crc_nxt   = '0;
        if (last_dev_eff || !item.presence) begin
          active_nxt   = 1'b0;
          ldisc_nxt    = '0;
          fam_nxt      = '0;
          last_dev_nxt = 1'b0;
          status       = ST_NONE;
        end else begin
          active_nxt = 1'b1;
          status     = ST_BUSY;
        end
      end
      FN_PAIR: begin
        if (active_r) begin
          dir = d;
          if (item.id_bit && item.complement_bit) begin
            // No device answered: abort the pass.
            active_nxt   = 1'b0;
            ldisc_nxt    = '0;
            fam_nxt      = '0;
            last_dev_nxt = 1'b0;
            status       = ST_NONE;
          end else begin
            if (!item.id_bit && !item.complement_bit && !d) begin
              lzero_nxt = pos_r;
              if (pos_r < FAMILY_LIMIT) fam_nxt = pos_r[3:0];
            end
            rom_nxt[idx] = d;
            crc_nxt      = crc_step(crc_r, d);
            pos_nxt      = pos_r + 7'd1;
            if (pos_nxt < END_POS) begin
              status = ST_BUSY;
            end else begin
              active_nxt = 1'b0;
              status     = ST_FOUND;
              if (crc_nxt == 8'd0) begin
                ldisc_nxt = lzero_nxt;
                if (lzero_nxt == 7'd0) last_dev_nxt = 1'b1;
              end
              if (crc_nxt != 8'd0 || rom_nxt[7:0] == 8'd0) begin
                ldisc_nxt    = '0;
                fam_nxt      = '0;
                last_dev_nxt = 1'b0;
                status       = ST_NONE;
              end
            end
          end
        end
      end
      default: status = ST_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_r      <= '0;
      ldisc_r    <= '0;
      fam_r      <= '0;
      last_dev_r <= 1'b0;
      pos_r      <= 7'd1;
      lzero_r    <= '0;
      crc_r      <= '0;
      active_r   <= 1'b0;
    end else if (fire) begin
      rom_r      <= rom_nxt;
      ldisc_r    <= ldisc_nxt;
      fam_r      <= fam_nxt;
      last_dev_r <= last_dev_nxt;
      pos_r      <= pos_nxt;
      lzero_r    <= lzero_nxt;
      crc_r      <= crc_nxt;
      active_r   <= active_nxt;
    end
  end

  assign res = '{direction: dir, status: status, rom_id: rom_nxt,
                 family_discrepancy: fam_nxt};

  `ORS_ASSERT_IMP(a_pos_range, active_r, pos_r >= 7'd1 && pos_r <= 7'd64, "bit position out of range in pass")
  `ORS_ASSERT_IMP(a_last_dev, last_dev_r, ldisc_r == 7'd0, "last device flagged with open discrepancy")
  `ORS_ASSERT_IMP(a_fam_range, 1'b1, fam_r <= 4'd8, "family discrepancy beyond family code")
  `ORS_ASSERT_NXT(a_found_crc, fire && res.status == ST_FOUND, crc_r == 8'd0 && !active_r, "device found with bad crc or live pass")

endmodule

@@ rtl/ors_out_stage.sv @@
module ors_out_stage
  import ors_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  input  out_item_t  res,
  output logic       take,
  ors_out_if.source  out_ch
);

  logic      valid_r;
  out_item_t res_r;

  // Advance whenever the result register is empty or drains this cycle.
  assign take = item_valid && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_ch.ready) begin
      valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res;
  end

  assign out_ch.valid              = valid_r;
  assign out_ch.direction          = res_r.direction;
  assign out_ch.status             = res_r.status;
  assign out_ch.rom_id             = res_r.rom_id;
  assign out_ch.family_discrepancy = res_r.family_discrepancy;

endmodule
